FILE: src/cdte_pkg.sv
// Package for the civil date to epoch seconds converter.
// Stage payload types, calendar constants and the cumulative month-days table.
// No dependencies.
package cdte_pkg;

	// floor(u/12) = (u * 5462) >> 16 for u < 4099
	localparam logic [12:0] RECIP12 = 13'd5462;
	// floor(u/25) = (u * 2622) >> 16 for u < 4239
	localparam logic [11:0] RECIP25 = 12'd2622;
	// month + 2051 = (month - 1) + 12*171, always non-negative
	localparam logic [12:0] MONTH_BIAS = 13'd2051;
	// yq = year + floor((month - 1)/12) + 400
	localparam logic [14:0] YEAR_BIAS = 15'd229;
	// 1970 + 400
	localparam logic signed [15:0] EPOCH_YQ = 16'sd2370;
	// 97 leap-count bias for the +400 shift, plus 477
	localparam logic signed [15:0] LEAP_BIAS = 16'sd574;
	localparam logic signed [9:0]  DAYS_PER_YEAR = 10'sd365;
	localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;
	localparam logic signed [12:0] SECS_PER_HOUR = 13'sd3600;
	localparam logic signed [7:0]  SECS_PER_MIN = 8'sd60;

	typedef struct packed {
		logic [13:0]        year;
		logic signed [11:0] month;
		logic signed [10:0] day;
		logic signed [10:0] hour;
		logic signed [12:0] minute;
		logic signed [16:0] second;
		logic [19:0]        micro;
	} cdte_date_t;

	typedef struct packed {
		logic [14:0]        yq;
		logic [3:0]         mon;
		logic signed [10:0] day;
		logic signed [23:0] tsec;
		logic [19:0]        micro;
	} cdte_norm_t;

	typedef struct packed {
		logic signed [23:0] days;
		logic signed [23:0] tsec;
		logic [19:0]        micro;
	} cdte_days_t;

	typedef struct packed {
		logic signed [38:0] epoch;
		logic [19:0]        micro;
	} cdte_stamp_t;

	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd2:    d = 9'd31;
			4'd3:    d = leap ? 9'd60  : 9'd59;
			4'd4:    d = leap ? 9'd91  : 9'd90;
			4'd5:    d = leap ? 9'd121 : 9'd120;
			4'd6:    d = leap ? 9'd152 : 9'd151;
			4'd7:    d = leap ? 9'd182 : 9'd181;
			4'd8:    d = leap ? 9'd213 : 9'd212;
			4'd9:    d = leap ? 9'd244 : 9'd243;
			4'd10:   d = leap ? 9'd274 : 9'd273;
			4'd11:   d = leap ? 9'd305 : 9'd304;
			4'd12:   d = leap ? 9'd335 : 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: src/cdte_if.sv
// Valid/ready channel interfaces for the date input and the epoch output.
// No dependencies.
interface cdte_date_if;
	logic               valid;
	logic               ready;
	logic [13:0]        year_in;
	logic signed [11:0] month_in;
	logic signed [10:0] day_in;
	logic signed [10:0] hour_in;
	logic signed [12:0] minute_in;
	logic signed [16:0] second_in;
	logic [19:0]        micro_in;

	modport source (output valid, year_in, month_in, day_in, hour_in, minute_in,
		second_in, micro_in, input ready);
	modport sink (input valid, year_in, month_in, day_in, hour_in, minute_in,
		second_in, micro_in, output ready);
endinterface

interface cdte_stamp_if;
	logic               valid;
	logic               ready;
	logic signed [38:0] epoch_seconds;
	logic [19:0]        micro_out;

	modport source (output valid, epoch_seconds, micro_out, input ready);
	modport sink (input valid, epoch_seconds, micro_out, output ready);
endinterface

FILE: src/cdte_norm.sv
// Stages 1-2: month normalization into year offset and month 1..12,
// and the time-of-day seconds sum. Depends on cdte_pkg.
module cdte_norm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cdte_pkg::cdte_date_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cdte_pkg::cdte_norm_t   out_data
);

	logic               v_s1, v_s2, en_s1, en_s2;
	logic [12:0]        u;
	logic [25:0]        q_prod;
	logic signed [22:0] hsec;
	logic signed [18:0] msec;

	logic [12:0]        u_s1;
	logic [8:0]         q_s1;
	logic [13:0]        year_s1;
	logic signed [10:0] day_s1;
	logic signed [22:0] hsec_s1;
	logic signed [18:0] msec_s1;
	logic signed [16:0] sec_s1;
	logic [19:0]        micro_s1;

	logic [12:0]        r;
	cdte_pkg::cdte_norm_t norm_d, norm_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign u      = 13'(in_data.month) + cdte_pkg::MONTH_BIAS;
	assign q_prod = 26'(u) * 26'(cdte_pkg::RECIP12);
	assign hsec   = 23'(in_data.hour) * 23'(cdte_pkg::SECS_PER_HOUR);
	assign msec   = 19'(in_data.minute) * 19'(cdte_pkg::SECS_PER_MIN);

	assign r            = u_s1 - 13'(q_s1) * 13'd12;
	assign norm_d.yq    = 15'(year_s1) + 15'(q_s1) + cdte_pkg::YEAR_BIAS;
	assign norm_d.mon   = r[3:0] + 4'd1;
	assign norm_d.day   = day_s1;
	assign norm_d.tsec  = 24'(hsec_s1) + 24'(msec_s1) + 24'(sec_s1);
	assign norm_d.micro = micro_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			u_s1     <= u;
			q_s1     <= q_prod[24:16];
			year_s1  <= in_data.year;
			day_s1   <= in_data.day;
			hsec_s1  <= hsec;
			msec_s1  <= msec;
			sec_s1   <= in_data.second;
			micro_s1 <= in_data.micro;
		end
		if (en_s2) norm_s2 <= norm_d;
	end

	assign out_valid = v_s2;
	assign out_data  = norm_s2;

endmodule

FILE: src/cdte_days.sv
// Stages 3-5: Gregorian leap counts, leap test and day count since the epoch.
// Depends on cdte_pkg.
module cdte_days (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cdte_pkg::cdte_norm_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cdte_pkg::cdte_days_t   out_data
);

	logic v_s3, v_s4, v_s5, en_s3, en_s4, en_s5;

	logic [23:0]        q_prod;
	logic [7:0]         q100_s3;
	cdte_pkg::cdte_norm_t norm_s3;

	logic [14:0]        r100, yq_m1;
	logic [7:0]         q100m;
	logic [12:0]        q4m;
	logic               leap;
	logic [8:0]         md;
	logic signed [15:0] yrel, lcd;
	logic signed [23:0] ydays;

	logic signed [23:0] ydays_s4;
	logic signed [15:0] lcd_s4;
	logic signed [23:0] tsec_s4;
	logic [19:0]        micro_s4;

	cdte_pkg::cdte_days_t days_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	// floor(yq/100) = floor((yq >> 2)/25)
	assign q_prod = 24'(in_data.yq[14:2]) * 24'(cdte_pkg::RECIP25);

	assign r100  = norm_s3.yq - 15'(q100_s3) * 15'd100;
	assign q100m = q100_s3 - 8'(r100 == 15'd0);
	assign yq_m1 = norm_s3.yq - 15'd1;
	assign q4m   = yq_m1[14:2];
	assign leap  = (norm_s3.yq[1:0] == 2'd0) &&
		((r100 != 15'd0) || (q100_s3[1:0] == 2'd0));
	assign md    = cdte_pkg::cum_days(leap, norm_s3.mon);
	assign yrel  = $signed(16'(norm_s3.yq)) - cdte_pkg::EPOCH_YQ;
	assign ydays = 24'(yrel) * 24'(cdte_pkg::DAYS_PER_YEAR);
	assign lcd   = $signed(16'(q4m)) - $signed(16'(q100m)) + $signed(16'(q100m[7:2]))
		- cdte_pkg::LEAP_BIAS + $signed(16'(md)) + 16'(norm_s3.day) - 16'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q100_s3 <= q_prod[23:16];
			norm_s3 <= in_data;
		end
		if (en_s4) begin
			ydays_s4 <= ydays;
			lcd_s4   <= lcd;
			tsec_s4  <= norm_s3.tsec;
			micro_s4 <= norm_s3.micro;
		end
		if (en_s5) begin
			days_s5.days  <= ydays_s4 + 24'(lcd_s4);
			days_s5.tsec  <= tsec_s4;
			days_s5.micro <= micro_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = days_s5;

endmodule

FILE: src/cdte_scale.sv
// Stages 6-7: days to seconds and the final sum with the time of day.
// Stage 7 is the output register. Depends on cdte_pkg.
module cdte_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cdte_pkg::cdte_days_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cdte_pkg::cdte_stamp_t  out_data
);

	logic               v_s6, v_s7, en_s6, en_s7;
	logic signed [39:0] prod;
	logic [38:0]        prod_s6;
	logic signed [23:0] tsec_s6;
	logic [19:0]        micro_s6;
	cdte_pkg::cdte_stamp_t stamp_s7;

	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	assign prod = 40'(in_data.days) * 40'(cdte_pkg::SECS_PER_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			prod_s6  <= prod[38:0];
			tsec_s6  <= in_data.tsec;
			micro_s6 <= in_data.micro;
		end
		if (en_s7) begin
			stamp_s7.epoch <= $signed(prod_s6 + 39'(tsec_s6));
			stamp_s7.micro <= micro_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_data  = stamp_s7;

endmodule

FILE: src/civil_date_to_epoch_seconds.sv
// Civil UTC date and time to signed epoch seconds, microseconds passed through.
// Each transaction passes in order through cdte_norm, cdte_days and cdte_scale.
// Throughput: one transaction per cycle; each stage holds and fills bubbles
// independently, so input ready drops only when all 7 stages are full and stalled.
// Reset (arst_n low) clears the stage valid bits only; data registers are not reset.
// Depends on cdte_pkg, cdte_if, cdte_norm, cdte_days, cdte_scale.
module civil_date_to_epoch_seconds (
	input  logic          clk,
	input  logic          arst_n,
	cdte_date_if.sink     date,
	cdte_stamp_if.source  stamp
);

	cdte_pkg::cdte_date_t  date_d;
	cdte_pkg::cdte_norm_t  norm_d;
	cdte_pkg::cdte_days_t  days_d;
	cdte_pkg::cdte_stamp_t stamp_d;
	logic norm_valid, norm_ready, days_valid, days_ready;

	assign date_d.year   = date.year_in;
	assign date_d.month  = date.month_in;
	assign date_d.day    = date.day_in;
	assign date_d.hour   = date.hour_in;
	assign date_d.minute = date.minute_in;
	assign date_d.second = date.second_in;
	assign date_d.micro  = date.micro_in;

	cdte_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date.valid),
		.in_ready  (date.ready),
		.in_data   (date_d),
		.out_valid (norm_valid),
		.out_ready (norm_ready),
		.out_data  (norm_d)
	);

	cdte_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (norm_valid),
		.in_ready  (norm_ready),
		.in_data   (norm_d),
		.out_valid (days_valid),
		.out_ready (days_ready),
		.out_data  (days_d)
	);

	cdte_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days_valid),
		.in_ready  (days_ready),
		.in_data   (days_d),
		.out_valid (stamp.valid),
		.out_ready (stamp.ready),
		.out_data  (stamp_d)
	);

	assign stamp.epoch_seconds = stamp_d.epoch;
	assign stamp.micro_out     = stamp_d.micro;

endmodule

FILE: src/cdte_chk.sv
// Port-level checker for civil_date_to_epoch_seconds, attached by bind.
// Tracks transactions in flight against the 7-stage pipeline.
module cdte_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [38:0] epoch_seconds,
	input logic [19:0]        micro_out
);

	logic [3:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else begin
			inflight_q <= inflight_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(epoch_seconds) && $stable(micro_out))
		else $error("result payload changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("result without a pending transaction");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'd7)
		else $error("more transactions in flight than pipeline stages");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> inflight_q == 4'd7 && out_valid && !out_ready)
		else $error("input stalled while the pipeline has room");

endmodule

bind civil_date_to_epoch_seconds cdte_chk u_cdte_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (date.valid),
	.in_ready      (date.ready),
	.out_valid     (stamp.valid),
	.out_ready     (stamp.ready),
	.epoch_seconds (stamp.epoch_seconds),
	.micro_out     (stamp.micro_out)
);

FILE: tb/tb_top.sv
// Self-checking testbench for civil_date_to_epoch_seconds.
// Drives date transactions, predicts epoch seconds per transaction and checks the stamp stream.
// Depends on cdte_pkg, the cdte_date_if / cdte_stamp_if channel interfaces and the DUT.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT    = 200000;
	localparam int  DRAIN_CYCLES   = 20;
	localparam int  RANDOM_PER_SET = 200;
	localparam int  REPORT_MAX     = 10;
	localparam longint CIVIL_EPOCH = 1970;
	localparam longint YEAR_DAYS   = 365;
	localparam longint LEAP_SHIFT  = 477;
	localparam longint DAY_SECS    = 86400;
	localparam longint HOUR_SECS   = 3600;
	localparam longint MIN_SECS    = 60;
	// days before each month, index 1 is January; second row for leap years
	localparam int MONTH_START [2][13] = '{
		'{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
		'{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
	};

	logic clk = 1'b0;
	logic arst_n;

	cdte_date_if  date_bus ();
	cdte_stamp_if stamp_bus ();

	civil_date_to_epoch_seconds i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.date   (date_bus),
		.stamp  (stamp_bus)
	);

	always #5 clk = ~clk;

	cdte_pkg::cdte_date_t  date_q [$];
	cdte_pkg::cdte_stamp_t stamp_expect_q [$];
	cdte_pkg::cdte_stamp_t stamp_want;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          date_taken;
	int          mismatches;
	int          cycles;

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint pos_mod(input longint a, input longint b);
		longint r;
		r = a % b;
		if (r < 0)
			r = r + b;
		return r;
	endfunction

	function automatic bit is_leap(input longint y);
		return pos_mod(y, 4) == 0 && (pos_mod(y, 100) != 0 || pos_mod(y, 400) == 0);
	endfunction

	function automatic cdte_pkg::cdte_stamp_t predict_stamp(input cdte_pkg::cdte_date_t d);
		longint yr, mon, off, days, secs;
		cdte_pkg::cdte_stamp_t s;
		yr  = longint'(d.year);
		mon = longint'(d.month);
		// month carries whole years, truncating division
		if (mon < 1) begin
			off = ((mon - 1) / 12) - 1;
			yr  = yr + off;
			mon = mon - 12 * off;
		end
		if (mon > 12) begin
			off = (mon - 1) / 12;
			yr  = yr + off;
			mon = mon - 12 * off;
		end
		days = (yr - CIVIL_EPOCH) * YEAR_DAYS + floor_div(yr - 1, 4) - floor_div(yr - 1, 100)
			+ floor_div(yr - 1, 400) - LEAP_SHIFT + longint'(MONTH_START[is_leap(yr)][mon])
			+ longint'(d.day) - 1;
		secs = days * DAY_SECS + longint'(d.hour) * HOUR_SECS + longint'(d.minute) * MIN_SECS
			+ longint'(d.second);
		s.epoch = secs[38:0];
		s.micro = d.micro;
		return s;
	endfunction

	function automatic cdte_pkg::cdte_date_t build_date(input int y, input int mo, input int dy,
		input int h, input int mi, input int sc, input int us);
		cdte_pkg::cdte_date_t d;
		d.year   = 14'(y);
		d.month  = 12'(mo);
		d.day    = 11'(dy);
		d.hour   = 11'(h);
		d.minute = 13'(mi);
		d.second = 17'(sc);
		d.micro  = 20'(us);
		return d;
	endfunction

	function automatic int signed_range(input int span);
		return int'($urandom_range(2 * span, 0)) - span;
	endfunction

	function automatic cdte_pkg::cdte_date_t random_date();
		cdte_pkg::cdte_date_t d;
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 25) begin
			// any bit pattern the fields allow
			d.year   = 14'($urandom);
			d.month  = 12'($urandom);
			d.day    = 11'($urandom);
			d.hour   = 11'($urandom);
			d.minute = 13'($urandom);
			d.second = 17'($urandom);
			d.micro  = 20'($urandom);
		end else begin
			d.year   = 14'($urandom_range(9999, 101));
			d.month  = ($urandom_range(99, 0) < 70) ? 12'($urandom_range(12, 1))
				: 12'(signed_range(1199));
			d.day    = ($urandom_range(99, 0) < 80) ? 11'($urandom_range(31, 1))
				: 11'(signed_range(1023));
			d.hour   = ($urandom_range(99, 0) < 80) ? 11'($urandom_range(23, 0))
				: 11'(signed_range(1023));
			d.minute = ($urandom_range(99, 0) < 80) ? 13'($urandom_range(59, 0))
				: 13'(signed_range(4095));
			d.second = ($urandom_range(99, 0) < 80) ? 17'($urandom_range(59, 0))
				: 17'(signed_range(65535));
			d.micro  = ($urandom_range(99, 0) < 90) ? 20'($urandom_range(999999, 0))
				: 20'($urandom);
		end
		return d;
	endfunction

	task automatic wait_drained();
		while (date_q.size() != 0 || date_bus.valid || stamp_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// driver: one transaction held until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!date_bus.valid || date_taken) begin
				if (date_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					date_bus.valid <= 1'b1;
					{date_bus.year_in, date_bus.month_in, date_bus.day_in, date_bus.hour_in,
						date_bus.minute_in, date_bus.second_in, date_bus.micro_in}
						<= date_q.pop_front();
				end else begin
					date_bus.valid <= 1'b0;
				end
			end
			date_taken = 1'b0;
			stamp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// monitor: predict on input transaction, compare on output transaction
	always @(posedge clk) begin
		if (date_bus.valid && date_bus.ready) begin
			stamp_expect_q.push_back(predict_stamp({date_bus.year_in, date_bus.month_in,
				date_bus.day_in, date_bus.hour_in, date_bus.minute_in, date_bus.second_in,
				date_bus.micro_in}));
			date_taken = 1'b1;
		end
		if (stamp_bus.valid && stamp_bus.ready) begin
			if (stamp_expect_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: unexpected stamp epoch=%0d micro=%0d", $realtime,
						stamp_bus.epoch_seconds, stamp_bus.micro_out);
				mismatches++;
			end else begin
				stamp_want = stamp_expect_q.pop_front();
				if (stamp_bus.epoch_seconds !== stamp_want.epoch
						|| stamp_bus.micro_out !== stamp_want.micro) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: stamp mismatch epoch exp=%0d got=%0d micro exp=%0d got=%0d",
							$realtime, stamp_want.epoch, stamp_bus.epoch_seconds,
							stamp_want.micro, stamp_bus.micro_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		date_bus.valid     = 1'b0;
		date_bus.year_in   = '0;
		date_bus.month_in  = '0;
		date_bus.day_in    = '0;
		date_bus.hour_in   = '0;
		date_bus.minute_in = '0;
		date_bus.second_in = '0;
		date_bus.micro_in  = '0;
		stamp_bus.ready    = 1'b0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		date_taken         = 1'b0;
		mismatches         = 0;
		cycles             = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		date_q.push_back(build_date(1970, 1, 1, 0, 0, 0, 0));
		date_q.push_back(build_date(101, 1, 1, 0, 0, 0, 0));
		date_q.push_back(build_date(9999, 12, 31, 23, 59, 59, 999999));
		date_q.push_back(build_date(1, 1, 1, 0, 0, 0, 0));
		date_q.push_back(build_date(0, 1, 1, 0, 0, 0, 0));
		date_q.push_back(build_date(0, -2048, 1, 0, 0, 0, 0));      // year below zero
		date_q.push_back(build_date(16383, 12, 31, 23, 59, 59, 0)); // wraps 39 bits
		date_q.push_back(build_date(2000, 2, 29, 12, 0, 0, 1));
		date_q.push_back(build_date(1900, 3, 1, 0, 0, 0, 2));
		date_q.push_back(build_date(2024, 3, 1, 0, 0, 0, 3));
		date_q.push_back(build_date(400, 2, 29, 0, 0, 0, 4));
		date_q.push_back(build_date(2023, 0, 15, 0, 0, 0, 5));
		date_q.push_back(build_date(2023, 13, 1, 0, 0, 0, 6));
		date_q.push_back(build_date(2023, -12, 1, 0, 0, 0, 7));
		date_q.push_back(build_date(2023, -1199, 1, 0, 0, 0, 8));
		date_q.push_back(build_date(2023, 1199, 1, 0, 0, 0, 9));
		date_q.push_back(build_date(16383, 2047, 1023, 1023, 4095, 65535, 1048575));
		date_q.push_back(build_date(0, -2048, -1024, -1024, -4096, -65536, 0));
		date_q.push_back(build_date(1970, 1, -1023, -1023, -4095, -65535, 0));
		date_q.push_back(build_date(1970, 1, 1023, 1023, 4095, 65535, 999999));
		date_q.push_back(build_date(1969, 12, 31, 23, 59, 59, 1000000)); // micro above range
		date_q.push_back(build_date(2038, 1, 19, 3, 14, 7, 500000));
		wait_drained();

		for (int set = 0; set < 3; set++) begin
			send_idle_pct = (set == 0) ? 28 : (set == 1) ? 80 : 0;
			recv_idle_pct = (set == 0) ? 80 : (set == 1) ? 28 : 0;
			for (int n = 0; n < RANDOM_PER_SET; n++)
				date_q.push_back(random_date());
			// sender holds off until every stamp of this set is back
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && stamp_expect_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: civil_date_to_epoch_seconds.f
src/cdte_pkg.sv
src/cdte_if.sv
src/cdte_norm.sv
src/cdte_days.sv
src/cdte_scale.sv
src/civil_date_to_epoch_seconds.sv
src/cdte_chk.sv
tb/tb_top.sv
